### rtl/core/btg_pkg.sv
// ----------------------------------------------------------------------------
// btg_pkg
// Shared types and opcode constants for the branch trampoline generator.
// ----------------------------------------------------------------------------
package btg_pkg;

  localparam int unsigned MaxWords = 5;
  localparam int unsigned CntW     = 3;

  localparam logic [31:0] OpB    = 32'h1400_0000;
  localparam logic [31:0] OpBl   = 32'h9400_0000;
  localparam logic [31:0] OpAdrp = 32'h9000_0000;
  localparam logic [31:0] OpAdd  = 32'h9100_0000;
  localparam logic [31:0] OpMovz = 32'hd280_0000;
  localparam logic [31:0] OpMovk = 32'hf280_0000;
  localparam logic [31:0] OpBr   = 32'hd61f_0000;
  localparam logic [31:0] OpBlr  = 32'hd63f_0000;

  localparam logic [CntW-1:0] CntNone  = 3'd0;
  localparam logic [CntW-1:0] CntOne   = 3'd1;
  localparam logic [CntW-1:0] CntAdrp  = 3'd3;
  localparam logic [CntW-1:0] CntMov   = 3'd5;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISALIGN = 2'd1,
    STAT_BAD_REG  = 2'd2
  } status_e;

  // One encoded sequence, words[0] goes out first.
  typedef struct packed {
    logic [MaxWords-1:0][31:0] words;
    logic [CntW-1:0]           cnt;
    status_e                   status;
  } seq_t;

endpackage

### rtl/core/btg_encoder.sv
// ----------------------------------------------------------------------------
// btg_encoder
// Combinational encoder: picks the branch form and builds all words of it.
// ----------------------------------------------------------------------------
module btg_encoder import btg_pkg::*; (
  input  logic [63:0] source_addr_i,
  input  logic [63:0] target_addr_i,
  input  logic        link_i,
  input  logic [7:0]  scratch_reg_i,
  output seq_t        seq_o
);

  logic [64:0] byte_diff;
  logic [52:0] page_diff;
  logic        misaligned;
  logic        near;
  logic        page_ok;
  logic [4:0]  rd;
  logic [31:0] br_word;

  // True signed differences, one extra bit so nothing wraps.
  assign byte_diff  = {1'b0, target_addr_i} - {1'b0, source_addr_i};
  assign page_diff  = {1'b0, target_addr_i[63:12]} - {1'b0, source_addr_i[63:12]};
  assign misaligned = (|source_addr_i[1:0]) | (|target_addr_i[1:0]);
  // In range when all bits above the field match its sign.
  assign near       = (&byte_diff[64:27]) | ~(|byte_diff[64:27]);
  assign page_ok    = (&page_diff[52:20]) | ~(|page_diff[52:20]);
  assign rd         = scratch_reg_i[4:0];
  assign br_word    = (link_i ? OpBlr : OpBr) | {22'd0, rd, 5'd0};

  always_comb begin
    seq_o.words  = '0;
    seq_o.cnt    = CntOne;
    seq_o.status = STAT_OK;
    if (misaligned) begin
      seq_o.status = STAT_MISALIGN;
    end else if (near) begin
      seq_o.words[0] = (link_i ? OpBl : OpB) | {6'd0, byte_diff[27:2]};
    end else if (|scratch_reg_i[7:5]) begin
      seq_o.status = STAT_BAD_REG;
    end else if (page_ok) begin
      seq_o.cnt      = CntAdrp;
      seq_o.words[0] = OpAdrp | {1'b0, page_diff[1:0], 5'd0, 24'd0}
                     | {8'd0, page_diff[20:2], 5'd0} | {27'd0, rd};
      seq_o.words[1] = OpAdd | {10'd0, target_addr_i[11:0], 10'd0}
                     | {22'd0, rd, 5'd0} | {27'd0, rd};
      seq_o.words[2] = br_word;
    end else begin
      seq_o.cnt = CntMov;
      for (int hw = 0; hw < 4; hw++) begin
        seq_o.words[hw] = ((hw == 0) ? OpMovz : OpMovk)
                        | {9'd0, 2'(hw), 21'd0}
                        | {11'd0, target_addr_i[16*hw +: 16], 5'd0}
                        | {27'd0, rd};
      end
      seq_o.words[4] = br_word;
    end
  end

endmodule

### rtl/core/btg_emitter.sv
// ----------------------------------------------------------------------------
// btg_emitter
// Result shift buffer: sends one word per cycle straight from flops.
// ----------------------------------------------------------------------------
module btg_emitter import btg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  seq_t        seq_i,
  output logic        free_o,
  output logic        strobe_o,
  output logic [31:0] word_o,
  output logic        last_o,
  output logic [1:0]  status_o
);

  logic [MaxWords-1:0][31:0] buf_q, buf_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  status_e                   status_q, status_d;

  // Free when empty or when the final word leaves this cycle.
  assign free_o   = (cnt_q == CntNone) || (cnt_q == CntOne);
  assign strobe_o = (cnt_q != CntNone);
  assign word_o   = buf_q[0];
  assign last_o   = (cnt_q == CntOne);
  assign status_o = status_q;

  always_comb begin
    buf_d    = buf_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    if (load_i) begin
      buf_d    = seq_i.words;
      cnt_d    = seq_i.cnt;
      status_d = seq_i.status;
    end else if (strobe_o) begin
      for (int i = 0; i < MaxWords - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      buf_d[MaxWords-1] = '0;
      cnt_d = cnt_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CntNone;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q    <= buf_d;
    status_q <= status_d;
  end

endmodule

### rtl/core/branch_trampoline_generator.sv
// ----------------------------------------------------------------------------
// branch_trampoline_generator
// AArch64 branch sequence encoder: B/BL, ADRP+ADD+BR/BLR or MOVZ/MOVK+BR/BLR.
// ----------------------------------------------------------------------------
// The start transfer is held in the input register, then loaded into the emitter,
// whose buffer drives the first word. Each item gives 1 to 5 result words; the
// words of consecutive items follow with no gap on the single result port when the next item already waits.
// busy holds while an item waits in the input register for the emitter.
// Reset clears the input valid flag and the word count; no result follows.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module branch_trampoline_generator import btg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] source_addr_i,
  input  logic [63:0] target_addr_i,
  input  logic        link_i,
  input  logic [7:0]  scratch_reg_i,
  output logic        strobe_o,
  output logic [31:0] word_o,
  output logic        last_o,
  output logic [1:0]  status_o
);

  // Input register
  logic        in_valid_q, in_valid_d;
  logic [63:0] src_q, tgt_q;
  logic        link_q;
  logic [7:0]  reg_q;

  logic        accept;
  logic        load;
  logic        emit_free;
  seq_t        seq;

  // The encoder output moves to the emitter as soon as it frees up, so the
  // input register empties every cycle while only short sequences run.
  assign load   = in_valid_q && emit_free;
  assign busy   = in_valid_q && !emit_free;
  assign accept = start && !busy;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (load) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q  <= source_addr_i;
      tgt_q  <= target_addr_i;
      link_q <= link_i;
      reg_q  <= scratch_reg_i;
    end
  end

  // Encode all words of the held item in one pass.
  btg_encoder u_encoder (
    .source_addr_i (src_q),
    .target_addr_i (tgt_q),
    .link_i        (link_q),
    .scratch_reg_i (reg_q),
    .seq_o         (seq)
  );

  // Shift out one word per cycle.
  btg_emitter u_emitter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load),
    .seq_i    (seq),
    .free_o   (emit_free),
    .strobe_o (strobe_o),
    .word_o   (word_o),
    .last_o   (last_o),
    .status_o (status_o)
  );

  // A stalled item always has one waiting in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> in_valid_q)
    else $error("busy without a held item");

  // A sequence runs without gaps until its last word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |=> strobe_o)
    else $error("gap inside a result sequence");

  // Error results are single words of zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o != STAT_OK) |-> last_o && (word_o == '0))
    else $error("error result not a single zero word");

  // Once handed to the emitter, an item leaves the input register
  // unless replaced by a fresh transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !accept |=> !in_valid_q)
    else $error("input register not released after load");

endmodule
